### hdl/ffra_pkg.sv
// shared types and constants for the frame flash risk analyzer
`timescale 1ns / 1ps
package ffra_pkg;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 23;

    localparam int CNT_W = 23;    // pixel positions and per-frame pixel counts
    localparam int PIX_W = 24;
    localparam int LEVEL_W = 8;
    localparam int VAR_W = 14;
    localparam int RISK_W = 7;
    localparam int STEPE_W = 10;
    localparam int STEPL_W = 11;
    localparam int EXT_W = 15;
    localparam int SAMP_W = 14;
    localparam int LUMA_W = 24;
    localparam int LSQ_W = 48;
    localparam int SUM_W = 38;
    localparam int SQ_W = 62;
    localparam int PROD_W = 76;
    localparam int DVD_W = 44;
    localparam int DSR_W = 28;
    localparam int Q_W = 15;
    localparam int BRI_W = 18;

    // ceil(2^37 / 10000), exact quotient for every 24-bit numerator
    localparam logic [23:0] RECIP_10K = 24'd13743896;
    localparam int RECIP_W = 47;

    localparam logic [Q_W-1:0] VAR_MAX = 15'd16256;

    localparam logic [RISK_W-1:0] W_FLASH = 7'd40;
    localparam logic [RISK_W-1:0] W_PATTERN = 7'd35;
    localparam logic [RISK_W-1:0] W_EXTREME = 7'd25;
    localparam logic [RISK_W-1:0] W_VARIANCE = 7'd20;

    localparam logic [CNT_W-1:0] RST_FRAME_PIXELS = 23'd2073600;
    localparam logic [LEVEL_W-1:0] RST_BRIGHT_LEVEL = 8'd200;
    localparam logic [LEVEL_W-1:0] RST_DARK_LEVEL = 8'd50;
    localparam logic [VAR_W-1:0] RST_VARIANCE_LIMIT = 14'd10000;
    localparam logic [RISK_W-1:0] RST_MALICIOUS_LIMIT = 7'd50;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_PIXELS    = 3'd0,
        REG_BRIGHT_LEVEL    = 3'd1,
        REG_DARK_LEVEL      = 3'd2,
        REG_VARIANCE_LIMIT  = 3'd3,
        REG_MALICIOUS_LIMIT = 3'd4
    } t_cfg_reg;

    typedef enum logic {
        MODE_MUL = 1'b0,
        MODE_DIV = 1'b1
    } t_arith_mode;

    typedef struct packed {
        logic              start;
        t_arith_mode       mode;
        logic [PROD_W-1:0] wide;     // multiplicand, or divisor in the low bits
        logic [DVD_W-1:0]  narrow;   // multiplier, or dividend
    } t_arith_req;

    typedef struct packed {
        logic              done;
        logic [PROD_W-1:0] product;
        logic [Q_W-1:0]    quot;
        logic              rem_nz;
    } t_arith_rsp;

endpackage

### hdl/ffra_arith.sv
// shared shift-add multiplier and restoring divider, one step per cycle
`timescale 1ns / 1ps
module ffra_arith (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  ffra_pkg::t_arith_req  i_req,
    output ffra_pkg::t_arith_rsp  o_rsp
);

    localparam int CW = $clog2(ffra_pkg::DVD_W);

    logic                            r_busy, n_busy;
    logic                            r_done, n_done;
    ffra_pkg::t_arith_mode           r_mode, n_mode;
    logic [ffra_pkg::PROD_W-1:0]     r_acc, n_acc;
    logic [ffra_pkg::PROD_W-1:0]     r_mc, n_mc;
    logic [ffra_pkg::DVD_W-1:0]      r_mp, n_mp;
    logic [ffra_pkg::DSR_W-1:0]      r_dsr, n_dsr;
    logic [ffra_pkg::DSR_W-1:0]      r_rem, n_rem;
    logic [ffra_pkg::Q_W-1:0]        r_q, n_q;
    logic [CW-1:0]                   r_cnt, n_cnt;
    logic [ffra_pkg::DSR_W:0]        w_rem_sh;
    logic                            w_fits;

    // restoring step: shift in the next dividend bit (the multiplier register holds it)
    assign w_rem_sh = {r_rem, r_mp[ffra_pkg::DVD_W-1]};
    assign w_fits   = w_rem_sh >= {1'b0, r_dsr};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_mode = r_mode;
        n_acc  = r_acc;
        n_mc   = r_mc;
        n_mp   = r_mp;
        n_dsr  = r_dsr;
        n_rem  = r_rem;
        n_q    = r_q;
        n_cnt  = r_cnt;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_mode = i_req.mode;
            n_acc  = '0;
            n_mc   = i_req.wide;
            n_mp   = i_req.narrow;
            n_dsr  = i_req.wide[ffra_pkg::DSR_W-1:0];
            n_rem  = '0;
            n_q    = '0;
            n_cnt  = CW'(ffra_pkg::DVD_W - 1);
        end else if (r_busy) begin
            case (r_mode)
                ffra_pkg::MODE_MUL: begin
                    n_acc = r_acc + (r_mp[0] ? r_mc : '0);
                    n_mc  = r_mc << 1;
                    n_mp  = r_mp >> 1;
                    if (n_mp == '0) begin
                        n_busy = 1'b0;
                        n_done = 1'b1;
                    end
                end
                ffra_pkg::MODE_DIV: begin
                    if (w_fits) begin
                        n_rem = ffra_pkg::DSR_W'(w_rem_sh - {1'b0, r_dsr});
                    end else begin
                        n_rem = w_rem_sh[ffra_pkg::DSR_W-1:0];
                    end
                    n_q   = {r_q[ffra_pkg::Q_W-2:0], w_fits};
                    n_mp  = r_mp << 1;
                    n_cnt = r_cnt - 1'b1;
                    if (r_cnt == '0) begin
                        n_busy = 1'b0;
                        n_done = 1'b1;
                    end
                end
                default: begin
                    n_busy = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_mode <= n_mode;
        r_acc  <= n_acc;
        r_mc   <= n_mc;
        r_mp   <= n_mp;
        r_dsr  <= n_dsr;
        r_rem  <= n_rem;
        r_q    <= n_q;
        r_cnt  <= n_cnt;
    end

    assign o_rsp.done    = r_done;
    assign o_rsp.product = r_acc;
    assign o_rsp.quot    = r_q;
    assign o_rsp.rem_nz  = r_rem != '0;

endmodule

### hdl/frame_flash_risk_analyzer_top.sv
// frame flash risk analyzer: per-pixel statistics and end-of-frame risk result
// a pixel is absorbed after its transfer through three datapath stages (PIX1, PIX2, PIX3)
// the next pixel is taken only in idle, after the last has left them; a frame's last pixel
// then runs the variance on the shared multiplier (up to 14+38+14 steps) and divider (44 steps)
// the result is registered and then waits for the sink
// reset: synchronous active low, registers return to their defaults and frame state clears
`timescale 1ns / 1ps
module frame_flash_risk_analyzer_top #(
    parameter int MAX_PIXELS  = 4194304,
    parameter int PAIR_WINDOW = 1000
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [ffra_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [ffra_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              i_pixel_valid,
    output logic                              o_pixel_ready,
    input  logic [ffra_pkg::PIX_W-1:0]        i_pixel_rgb,
    output logic                              o_result_valid,
    input  logic                              i_result_ready,
    output logic                              o_flashing_flag,
    output logic                              o_pattern_flag,
    output logic                              o_extreme_flag,
    output logic [ffra_pkg::VAR_W-1:0]        o_luma_variance,
    output logic [ffra_pkg::RISK_W-1:0]       o_threat_score,
    output logic                              o_malicious_flag
);

    localparam int TW = $clog2(PAIR_WINDOW);
    localparam int CW = ffra_pkg::CNT_W;

    typedef enum logic [10:0] {
        ST_IDLE  = 11'b00000000001,
        ST_PIX1  = 11'b00000000010,
        ST_PIX2  = 11'b00000000100,
        ST_PIX3  = 11'b00000001000,
        ST_FIN   = 11'b00000010000,
        ST_MUL_A = 11'b00000100000,
        ST_MUL_S = 11'b00001000000,
        ST_MUL_D = 11'b00010000000,
        ST_SUB   = 11'b00100000000,
        ST_DIV   = 11'b01000000000,
        ST_OUT   = 11'b10000000000
    } t_state;

    t_state r_state, n_state;

    // configuration
    logic [CW-1:0]                      r_frame_pixels, n_frame_pixels;
    logic [ffra_pkg::LEVEL_W-1:0]       r_bright_level, n_bright_level;
    logic [ffra_pkg::LEVEL_W-1:0]       r_dark_level, n_dark_level;
    logic [ffra_pkg::VAR_W-1:0]         r_var_limit, n_var_limit;
    logic [ffra_pkg::RISK_W-1:0]        r_mal_limit, n_mal_limit;

    // frame state
    logic [CW-1:0]                      r_idx, n_idx;
    logic [CW-1:0]                      r_bright, n_bright;
    logic [CW-1:0]                      r_dark, n_dark;
    logic [ffra_pkg::PIX_W-1:0]         r_prev, n_prev;
    logic [TW-1:0]                      r_trans, n_trans;
    logic [ffra_pkg::EXT_W-1:0]         r_ext, n_ext;
    logic [ffra_pkg::EXT_W-1:0]         r_wraps, n_wraps;
    logic [ffra_pkg::STEPE_W-1:0]       r_e_phase, n_e_phase;
    logic [ffra_pkg::STEPL_W-1:0]       r_l_phase, n_l_phase;
    logic [ffra_pkg::SAMP_W-1:0]        r_samples, n_samples;
    logic [ffra_pkg::SUM_W-1:0]         r_sum, n_sum;
    logic [ffra_pkg::SQ_W-1:0]          r_sq, n_sq;

    // pixel pipeline
    logic [ffra_pkg::PIX_W-1:0]         r_pix, n_pix;
    logic [ffra_pkg::LUMA_W-1:0]        r_lum, n_lum;
    logic [ffra_pkg::LSQ_W-1:0]         r_lsq, n_lsq;
    logic                               r_l_hit, n_l_hit;
    logic                               r_last, n_last;

    // end of frame
    logic [ffra_pkg::PROD_W-1:0]        r_a, n_a;
    logic [ffra_pkg::PROD_W-1:0]        r_s, n_s;
    logic [ffra_pkg::DSR_W-1:0]         r_d2, n_d2;
    logic                               r_lo_nz, n_lo_nz;
    logic [ffra_pkg::Q_W-1:0]           r_q, n_q;
    logic                               r_rem_nz, n_rem_nz;
    logic                               r_var_ok, n_var_ok;

    // result register
    logic                               r_out_valid, n_out_valid;
    logic                               r_o_flash, n_o_flash;
    logic                               r_o_pattern, n_o_pattern;
    logic                               r_o_extreme, n_o_extreme;
    logic [ffra_pkg::VAR_W-1:0]         r_o_var, n_o_var;
    logic [ffra_pkg::RISK_W-1:0]        r_o_risk, n_o_risk;
    logic                               r_o_mal, n_o_mal;

    logic [ffra_pkg::STEPE_W-1:0]       r_step_e;
    logic [ffra_pkg::STEPL_W-1:0]       r_step_l;

    ffra_pkg::t_arith_req               w_req;
    ffra_pkg::t_arith_rsp               w_rsp;

    logic [CW-1:0]                      w_n;
    logic [CW-1:0]                      w_win;
    logic [ffra_pkg::RECIP_W-1:0]       w_recip;
    logic [ffra_pkg::STEPE_W-1:0]       w_step_e;
    logic [ffra_pkg::STEPL_W-1:0]       w_step_l;

    logic [7:0]                         w_r, w_g, w_b, w_pr, w_pg, w_pb;
    logic [7:0]                         w_dr, w_dg, w_db;
    logic [ffra_pkg::BRI_W-1:0]         w_bri;
    logic                               w_is_bright, w_is_dark;
    logic                               w_trans_hit, w_extreme_pix;
    logic [ffra_pkg::STEPE_W:0]         w_e_next;
    logic [ffra_pkg::STEPL_W:0]         w_l_next;
    logic [ffra_pkg::LUMA_W-1:0]        w_lum;
    logic [ffra_pkg::PROD_W-1:0]        w_num;

    logic                               w_flash, w_pattern, w_extreme, w_var_high;
    logic [ffra_pkg::VAR_W-1:0]         w_var;
    logic [ffra_pkg::RISK_W-1:0]        w_risk;
    logic                               w_out_free;

    // effective frame size and sampling steps
    always_comb begin
        w_n = r_frame_pixels;
        if (w_n == '0) begin
            w_n = CW'(1);
        end else if ({2'b00, w_n} > (CW + 2)'(MAX_PIXELS)) begin
            w_n = CW'(MAX_PIXELS);
        end
        w_win = ({2'b00, w_n} < (CW + 2)'(PAIR_WINDOW)) ? w_n : CW'(PAIR_WINDOW);
    end

    assign w_recip = ffra_pkg::RECIP_W'(w_n) * ffra_pkg::RECIP_W'(ffra_pkg::RECIP_10K);
    assign w_step_e = (w_recip[46:37] == '0) ? ffra_pkg::STEPE_W'(1) : w_recip[46:37];
    assign w_step_l = (w_recip[46:36] == '0) ? ffra_pkg::STEPL_W'(1) : w_recip[46:36];

    always_ff @(posedge i_clk) begin
        r_step_e <= w_step_e;
        r_step_l <= w_step_l;
    end

    // pixel classification on the registered pixel
    always_comb begin
        w_r  = r_pix[23:16];
        w_g  = r_pix[15:8];
        w_b  = r_pix[7:0];
        w_pr = r_prev[23:16];
        w_pg = r_prev[15:8];
        w_pb = r_prev[7:0];
        w_dr = (w_pr > w_r) ? w_pr - w_r : w_r - w_pr;
        w_dg = (w_pg > w_g) ? w_pg - w_g : w_g - w_pg;
        w_db = (w_pb > w_b) ? w_pb - w_b : w_b - w_pb;
        w_bri = ffra_pkg::BRI_W'(w_r) * 18'd299 + ffra_pkg::BRI_W'(w_g) * 18'd587
              + ffra_pkg::BRI_W'(w_b) * 18'd114;
        // floor(s/1000) > level  <=>  s >= 1000*(level+1)
        w_is_bright = w_bri >= (ffra_pkg::BRI_W'(r_bright_level) + 18'd1) * 18'd1000;
        w_is_dark   = !w_is_bright && (w_bri < ffra_pkg::BRI_W'(r_dark_level) * 18'd1000);
        w_trans_hit = (r_idx != '0) && (r_idx < w_win)
                    && ((w_dr > 8'd128) || (w_dg > 8'd128) || (w_db > 8'd128));
        w_extreme_pix = ((w_r > 8'd240) && (w_g > 8'd240) && (w_b > 8'd240))
                      || ((w_r < 8'd15) && (w_g < 8'd15) && (w_b < 8'd15));
        w_e_next = {1'b0, r_e_phase} + 1'b1;
        w_l_next = {1'b0, r_l_phase} + 1'b1;
        w_lum = ffra_pkg::LUMA_W'(w_r) * 24'd13933 + ffra_pkg::LUMA_W'(w_g) * 24'd46871
              + ffra_pkg::LUMA_W'(w_b) * 24'd4732;
    end

    assign w_num = (r_a > r_s) ? r_a - r_s : '0;

    // frame verdict
    always_comb begin
        w_flash = (27'(r_bright) * 27'd10 > 27'(w_n) * 27'd7)
               || (27'(r_dark) * 27'd10 > 27'(w_n) * 27'd7);
        w_pattern = 28'(r_trans) * 28'd10 > 28'(w_win) * 28'd3;
        w_extreme = 20'(r_ext) * 20'd10 > 20'(r_wraps) * 20'd4;
        w_var_high = r_var_ok
            && ((r_q > ffra_pkg::Q_W'(r_var_limit))
                || ((r_q == ffra_pkg::Q_W'(r_var_limit)) && (r_rem_nz || r_lo_nz)));
        if (!r_var_ok) begin
            w_var = '0;
        end else if (r_q > ffra_pkg::VAR_MAX) begin
            w_var = ffra_pkg::VAR_MAX[ffra_pkg::VAR_W-1:0];
        end else begin
            w_var = r_q[ffra_pkg::VAR_W-1:0];
        end
        w_risk = (w_flash ? ffra_pkg::W_FLASH : '0) + (w_pattern ? ffra_pkg::W_PATTERN : '0)
               + (w_extreme ? ffra_pkg::W_EXTREME : '0)
               + (w_var_high ? ffra_pkg::W_VARIANCE : '0);
    end

    assign w_out_free = !r_out_valid || i_result_ready;

    always_comb begin
        n_state        = r_state;
        n_frame_pixels = r_frame_pixels;
        n_bright_level = r_bright_level;
        n_dark_level   = r_dark_level;
        n_var_limit    = r_var_limit;
        n_mal_limit    = r_mal_limit;
        n_idx     = r_idx;
        n_bright  = r_bright;
        n_dark    = r_dark;
        n_prev    = r_prev;
        n_trans   = r_trans;
        n_ext     = r_ext;
        n_wraps   = r_wraps;
        n_e_phase = r_e_phase;
        n_l_phase = r_l_phase;
        n_samples = r_samples;
        n_sum     = r_sum;
        n_sq      = r_sq;
        n_pix     = r_pix;
        n_lum     = r_lum;
        n_lsq     = r_lsq;
        n_l_hit   = r_l_hit;
        n_last    = r_last;
        n_a       = r_a;
        n_s       = r_s;
        n_d2      = r_d2;
        n_lo_nz   = r_lo_nz;
        n_q       = r_q;
        n_rem_nz  = r_rem_nz;
        n_var_ok  = r_var_ok;
        n_out_valid = r_out_valid && !i_result_ready;
        n_o_flash   = r_o_flash;
        n_o_pattern = r_o_pattern;
        n_o_extreme = r_o_extreme;
        n_o_var     = r_o_var;
        n_o_risk    = r_o_risk;
        n_o_mal     = r_o_mal;
        w_req.start  = 1'b0;
        w_req.mode   = ffra_pkg::MODE_MUL;
        w_req.wide   = '0;
        w_req.narrow = '0;

        case (r_state)
            ST_IDLE: begin
                if (i_pixel_valid) begin
                    n_pix   = i_pixel_rgb;
                    n_state = ST_PIX1;
                end
            end
            ST_PIX1: begin
                if (w_is_bright) n_bright = r_bright + 1'b1;
                if (w_is_dark) n_dark = r_dark + 1'b1;
                if (w_trans_hit) n_trans = r_trans + 1'b1;
                if ((r_e_phase == '0) && w_extreme_pix) n_ext = r_ext + 1'b1;
                if (w_e_next >= {1'b0, r_step_e}) begin
                    n_e_phase = '0;
                    n_wraps   = r_wraps + 1'b1;
                end else begin
                    n_e_phase = w_e_next[ffra_pkg::STEPE_W-1:0];
                end
                if (w_l_next >= {1'b0, r_step_l}) begin
                    n_l_phase = '0;
                end else begin
                    n_l_phase = w_l_next[ffra_pkg::STEPL_W-1:0];
                end
                n_l_hit = r_l_phase == '0;
                n_lum   = w_lum;
                n_prev  = r_pix;
                n_last  = ({1'b0, r_idx} + 1'b1) >= {1'b0, w_n};
                n_idx   = r_idx + 1'b1;
                n_state = ST_PIX2;
            end
            ST_PIX2: begin
                n_lsq   = ffra_pkg::LSQ_W'(r_lum) * ffra_pkg::LSQ_W'(r_lum);
                n_state = ST_PIX3;
            end
            ST_PIX3: begin
                if (r_l_hit) begin
                    n_samples = r_samples + 1'b1;
                    n_sum     = r_sum + ffra_pkg::SUM_W'(r_lum);
                    n_sq      = r_sq + ffra_pkg::SQ_W'(r_lsq);
                end
                n_state = r_last ? ST_FIN : ST_IDLE;
            end
            ST_FIN: begin
                if (r_samples >= ffra_pkg::SAMP_W'(2)) begin
                    n_var_ok     = 1'b1;
                    w_req.start  = 1'b1;
                    w_req.wide   = ffra_pkg::PROD_W'(r_sq);
                    w_req.narrow = ffra_pkg::DVD_W'(r_samples);
                    n_state      = ST_MUL_A;
                end else begin
                    n_var_ok = 1'b0;
                    n_state  = ST_OUT;
                end
            end
            ST_MUL_A: begin
                if (w_rsp.done) begin
                    n_a          = w_rsp.product;
                    w_req.start  = 1'b1;
                    w_req.wide   = ffra_pkg::PROD_W'(r_sum);
                    w_req.narrow = ffra_pkg::DVD_W'(r_sum);
                    n_state      = ST_MUL_S;
                end
            end
            ST_MUL_S: begin
                if (w_rsp.done) begin
                    n_s          = w_rsp.product;
                    w_req.start  = 1'b1;
                    w_req.wide   = ffra_pkg::PROD_W'(r_samples);
                    w_req.narrow = ffra_pkg::DVD_W'(r_samples);
                    n_state      = ST_MUL_D;
                end
            end
            ST_MUL_D: begin
                if (w_rsp.done) begin
                    n_d2    = w_rsp.product[ffra_pkg::DSR_W-1:0];
                    n_state = ST_SUB;
                end
            end
            ST_SUB: begin
                // divide by n^2 * 2^32: drop the low 32 bits, keep them for the exact compare
                n_lo_nz      = w_num[31:0] != '0;
                w_req.start  = 1'b1;
                w_req.mode   = ffra_pkg::MODE_DIV;
                w_req.wide   = ffra_pkg::PROD_W'(r_d2);
                w_req.narrow = w_num[ffra_pkg::PROD_W-1:32];
                n_state      = ST_DIV;
            end
            ST_DIV: begin
                if (w_rsp.done) begin
                    n_q      = w_rsp.quot;
                    n_rem_nz = w_rsp.rem_nz;
                    n_state  = ST_OUT;
                end
            end
            ST_OUT: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_o_flash   = w_flash;
                    n_o_pattern = w_pattern;
                    n_o_extreme = w_extreme;
                    n_o_var     = w_var;
                    n_o_risk    = w_risk;
                    n_o_mal     = w_risk > r_mal_limit;
                    n_idx     = '0;
                    n_bright  = '0;
                    n_dark    = '0;
                    n_prev    = '0;
                    n_trans   = '0;
                    n_ext     = '0;
                    n_wraps   = '0;
                    n_e_phase = '0;
                    n_l_phase = '0;
                    n_samples = '0;
                    n_sum     = '0;
                    n_sq      = '0;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (i_cfg_we) begin
            case (i_cfg_index)
                ffra_pkg::REG_FRAME_PIXELS: begin
                    n_frame_pixels = i_cfg_data;
                    n_idx     = '0;
                    n_bright  = '0;
                    n_dark    = '0;
                    n_prev    = '0;
                    n_trans   = '0;
                    n_ext     = '0;
                    n_wraps   = '0;
                    n_e_phase = '0;
                    n_l_phase = '0;
                    n_samples = '0;
                    n_sum     = '0;
                    n_sq      = '0;
                end
                ffra_pkg::REG_BRIGHT_LEVEL: n_bright_level = i_cfg_data[ffra_pkg::LEVEL_W-1:0];
                ffra_pkg::REG_DARK_LEVEL: n_dark_level = i_cfg_data[ffra_pkg::LEVEL_W-1:0];
                ffra_pkg::REG_VARIANCE_LIMIT: n_var_limit = i_cfg_data[ffra_pkg::VAR_W-1:0];
                ffra_pkg::REG_MALICIOUS_LIMIT: n_mal_limit = i_cfg_data[ffra_pkg::RISK_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_frame_pixels <= ffra_pkg::RST_FRAME_PIXELS;
            r_bright_level <= ffra_pkg::RST_BRIGHT_LEVEL;
            r_dark_level   <= ffra_pkg::RST_DARK_LEVEL;
            r_var_limit    <= ffra_pkg::RST_VARIANCE_LIMIT;
            r_mal_limit    <= ffra_pkg::RST_MALICIOUS_LIMIT;
            r_idx          <= '0;
            r_bright       <= '0;
            r_dark         <= '0;
            r_prev         <= '0;
            r_trans        <= '0;
            r_ext          <= '0;
            r_wraps        <= '0;
            r_e_phase      <= '0;
            r_l_phase      <= '0;
            r_samples      <= '0;
            r_sum          <= '0;
            r_sq           <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_frame_pixels <= n_frame_pixels;
            r_bright_level <= n_bright_level;
            r_dark_level   <= n_dark_level;
            r_var_limit    <= n_var_limit;
            r_mal_limit    <= n_mal_limit;
            r_idx          <= n_idx;
            r_bright       <= n_bright;
            r_dark         <= n_dark;
            r_prev         <= n_prev;
            r_trans        <= n_trans;
            r_ext          <= n_ext;
            r_wraps        <= n_wraps;
            r_e_phase      <= n_e_phase;
            r_l_phase      <= n_l_phase;
            r_samples      <= n_samples;
            r_sum          <= n_sum;
            r_sq           <= n_sq;
            r_out_valid    <= n_out_valid;
        end
        r_pix       <= n_pix;
        r_lum       <= n_lum;
        r_lsq       <= n_lsq;
        r_l_hit     <= n_l_hit;
        r_last      <= n_last;
        r_a         <= n_a;
        r_s         <= n_s;
        r_d2        <= n_d2;
        r_lo_nz     <= n_lo_nz;
        r_q         <= n_q;
        r_rem_nz    <= n_rem_nz;
        r_var_ok    <= n_var_ok;
        r_o_flash   <= n_o_flash;
        r_o_pattern <= n_o_pattern;
        r_o_extreme <= n_o_extreme;
        r_o_var     <= n_o_var;
        r_o_risk    <= n_o_risk;
        r_o_mal     <= n_o_mal;
    end

    ffra_arith u_arith (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    assign o_pixel_ready    = r_state == ST_IDLE;
    assign o_result_valid   = r_out_valid;
    assign o_flashing_flag  = r_o_flash;
    assign o_pattern_flag   = r_o_pattern;
    assign o_extreme_flag   = r_o_extreme;
    assign o_luma_variance  = r_o_var;
    assign o_threat_score   = r_o_risk;
    assign o_malicious_flag = r_o_mal;

endmodule

### hdl/ffra_checker.sv
// port-level checks for the frame flash risk analyzer, bound to the top level
`timescale 1ns / 1ps
module ffra_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [ffra_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [ffra_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              i_pixel_valid,
    input  logic                              o_pixel_ready,
    input  logic [ffra_pkg::PIX_W-1:0]        i_pixel_rgb,
    input  logic                              o_result_valid,
    input  logic                              i_result_ready,
    input  logic                              o_flashing_flag,
    input  logic                              o_pattern_flag,
    input  logic                              o_extreme_flag,
    input  logic [ffra_pkg::VAR_W-1:0]        o_luma_variance,
    input  logic [ffra_pkg::RISK_W-1:0]       o_threat_score,
    input  logic                              o_malicious_flag
);

    logic [ffra_pkg::RISK_W-1:0] w_base;

    assign w_base = (o_flashing_flag ? ffra_pkg::W_FLASH : '0)
                  + (o_pattern_flag ? ffra_pkg::W_PATTERN : '0)
                  + (o_extreme_flag ? ffra_pkg::W_EXTREME : '0);

    // no result survives reset
    a_reset_clear: assert property (@(posedge i_clk) !i_rst_n |=> !o_result_valid)
        else $error("result valid after reset");

    // a stalled result keeps its score, variance and malicious flag
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && !i_result_ready |=> o_result_valid && $stable(o_threat_score)
            && $stable(o_luma_variance) && $stable(o_malicious_flag))
        else $error("stalled result changed");

    // score is the sum of the raised indicator weights
    a_score: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> (o_threat_score == w_base)
            || (o_threat_score == w_base + ffra_pkg::W_VARIANCE))
        else $error("threat score does not match flags");

    // zero risk can never pass the malicious limit
    a_mal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && (o_threat_score == '0) |-> !o_malicious_flag)
        else $error("malicious with zero risk");

    a_var_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> ({1'b0, o_luma_variance} <= ffra_pkg::VAR_MAX))
        else $error("variance above bound");

endmodule

bind frame_flash_risk_analyzer_top ffra_checker u_ffra_checker (.*);
